// ===== hdl/gstd_pkg.sv =====
// ----------------------------------------------------------------------------
// gstd_pkg
// Shared types and constants for the group-serialized task dispatch queue.
// ----------------------------------------------------------------------------
package gstd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int GROUP_COUNT = 256;
    localparam int TAG_BITS    = 16;

    localparam int QIDX_BITS  = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int GIDX_BITS  = $clog2(GROUP_COUNT);
    localparam int ENTRY_BITS = TAG_BITS + 1 + GIDX_BITS;

    typedef enum logic [1:0] {
        OP_ENQUEUE  = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NONE     = 2'd2,
        ST_IDLE_GRP = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] task_tag;
        logic        group_valid;
        logic [7:0]  group_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        dispatched;
        logic [15:0] out_task_tag;
        logic        out_group_valid;
        logic [7:0]  out_group_id;
        logic [4:0]  queue_count;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP_RD,
        S_CMP_WR,
        S_SCAN_RD,
        S_SCAN_BUSY,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_MARK,
        S_CLEAR,
        S_OUT
    } state_t;

endpackage

// ===== hdl/gstd_stream_if.sv =====
// ----------------------------------------------------------------------------
// gstd_stream_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
interface gstd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/gstd_ram.sv =====
// ----------------------------------------------------------------------------
// gstd_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gstd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/group_serialized_task_dispatch_top.sv =====
// ----------------------------------------------------------------------------
// group_serialized_task_dispatch_top
// Ordered task queue with per-group serialization of dispatch.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_ch   | in  | op, task_tag, group_valid, group_id
// out_ch  | out | status, dispatched, out_task_tag, out_group_valid,
//         |     | out_group_id, queue_count
// Enqueue writes at the tail. Completion reads, then clears the busy bit.
// Dispatch reads each scanned entry, then its busy bit, then moves later
// entries up, serialized by the single read ports of queue and busy RAM.
// After reset a clearing pass over all GROUP_COUNT entries zeroes the busy
// RAM; no item is taken during it. One item is in work at a time; the result
// register holds until taken, and the next item is taken in the meantime.
// ----------------------------------------------------------------------------
module group_serialized_task_dispatch_top (
    input  logic clk,
    input  logic rst_n,
    gstd_stream_if.sink   in_ch,
    gstd_stream_if.source out_ch
);
    gstd_pkg::state_t state_reg, state_next;
    gstd_pkg::in_item_t item_reg, item_next;
    gstd_pkg::out_item_t res_reg, res_next;
    gstd_pkg::out_item_t acc_reg, acc_next;
    logic out_valid_reg, out_valid_next;
    logic [gstd_pkg::COUNT_BITS-1:0] count_reg, count_next;
    logic [gstd_pkg::COUNT_BITS-1:0] idx_reg, idx_next;
    logic [gstd_pkg::GIDX_BITS-1:0] clr_reg, clr_next;
    logic [gstd_pkg::ENTRY_BITS-1:0] ent_reg, ent_next;

    logic q_we;
    logic [gstd_pkg::QIDX_BITS-1:0] q_waddr, q_raddr;
    logic [gstd_pkg::ENTRY_BITS-1:0] q_wdata, q_rdata;
    logic b_we;
    logic [gstd_pkg::GIDX_BITS-1:0] b_waddr, b_raddr;
    logic [0:0] b_wdata, b_rdata;

    logic [gstd_pkg::TAG_BITS-1:0] e_tag;
    logic e_gv;
    logic [gstd_pkg::GIDX_BITS-1:0] e_grp, in_grp;

    gstd_ram #(.WIDTH(gstd_pkg::ENTRY_BITS), .DEPTH(gstd_pkg::QUEUE_DEPTH)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    gstd_ram #(.WIDTH(1), .DEPTH(gstd_pkg::GROUP_COUNT)) u_busy (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    assign e_tag = ent_reg[gstd_pkg::ENTRY_BITS-1 -: gstd_pkg::TAG_BITS];
    assign e_gv  = ent_reg[gstd_pkg::GIDX_BITS];
    assign e_grp = ent_reg[gstd_pkg::GIDX_BITS-1:0];
    assign in_grp = gstd_pkg::GIDX_BITS'(item_reg.group_id % gstd_pkg::GROUP_COUNT);

    assign in_ch.ready = (state_reg == gstd_pkg::S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gstd_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        acc_reg  <= acc_next;
        ent_reg  <= ent_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        clr_next       = clr_reg;
        ent_next       = ent_reg;
        q_we    = 1'b0;
        q_waddr = idx_reg[gstd_pkg::QIDX_BITS-1:0];
        q_wdata = ent_reg;
        q_raddr = idx_reg[gstd_pkg::QIDX_BITS-1:0];
        b_we    = 1'b0;
        b_waddr = in_grp;
        b_wdata = 1'b0;
        b_raddr = in_grp;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            gstd_pkg::S_CLEAR:
            begin
                b_we     = 1'b1;
                b_waddr  = clr_reg;
                b_wdata  = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == gstd_pkg::GIDX_BITS'(gstd_pkg::GROUP_COUNT - 1))
                begin
                    state_next = gstd_pkg::S_IDLE;
                end
            end
            gstd_pkg::S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    item_next = in_ch.data;
                    acc_next  = '0;
                    idx_next  = '0;
                    case (gstd_pkg::op_t'(in_ch.data.op))
                        gstd_pkg::OP_ENQUEUE:
                        begin
                            if (count_reg >= gstd_pkg::COUNT_BITS'(gstd_pkg::QUEUE_DEPTH))
                            begin
                                acc_next.status = gstd_pkg::ST_FULL;
                                state_next = gstd_pkg::S_OUT;
                            end
                            else
                            begin
                                q_we    = 1'b1;
                                q_waddr = count_reg[gstd_pkg::QIDX_BITS-1:0];
                                q_wdata = {gstd_pkg::TAG_BITS'(in_ch.data.task_tag),
                                    in_ch.data.group_valid,
                                    gstd_pkg::GIDX_BITS'(in_ch.data.group_id
                                        % gstd_pkg::GROUP_COUNT)};
                                count_next = count_reg + 1'b1;
                                state_next = gstd_pkg::S_OUT;
                            end
                        end
                        gstd_pkg::OP_DISPATCH:
                        begin
                            state_next = gstd_pkg::S_SCAN_RD;
                        end
                        gstd_pkg::OP_COMPLETE:
                        begin
                            state_next = in_ch.data.group_valid ? gstd_pkg::S_CMP_RD
                                                                : gstd_pkg::S_OUT;
                        end
                        default:
                        begin
                            state_next = gstd_pkg::S_OUT;
                        end
                    endcase
                end
            end
            gstd_pkg::S_CMP_RD:
            begin
                state_next = gstd_pkg::S_CMP_WR;
            end
            gstd_pkg::S_CMP_WR:
            begin
                if (b_rdata[0])
                begin
                    b_we = 1'b1;
                end
                else
                begin
                    acc_next.status = gstd_pkg::ST_IDLE_GRP;
                end
                state_next = gstd_pkg::S_OUT;
            end
            gstd_pkg::S_SCAN_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    acc_next.status = gstd_pkg::ST_NONE;
                    state_next = gstd_pkg::S_OUT;
                end
                else
                begin
                    state_next = gstd_pkg::S_SCAN_BUSY;
                end
            end
            gstd_pkg::S_SCAN_BUSY:
            begin
                ent_next   = q_rdata;
                state_next = gstd_pkg::S_SCAN_CHK;
            end
            gstd_pkg::S_SCAN_CHK:
            begin
                b_raddr = e_grp;
                state_next = gstd_pkg::S_MARK;
            end
            gstd_pkg::S_MARK:
            begin
                if (e_gv && b_rdata[0])
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = gstd_pkg::S_SCAN_RD;
                end
                else
                begin
                    if (e_gv)
                    begin
                        b_we    = 1'b1;
                        b_waddr = e_grp;
                        b_wdata = 1'b1;
                    end
                    acc_next.dispatched      = 1'b1;
                    acc_next.out_task_tag    = 16'(e_tag);
                    acc_next.out_group_valid = e_gv;
                    acc_next.out_group_id    = 8'(e_grp);
                    state_next = gstd_pkg::S_SHIFT_RD;
                end
            end
            gstd_pkg::S_SHIFT_RD:
            begin
                if (idx_reg + 1'b1 >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = gstd_pkg::S_OUT;
                end
                else
                begin
                    q_raddr = gstd_pkg::QIDX_BITS'(idx_reg + 1'b1);
                    state_next = gstd_pkg::S_SHIFT_WR;
                end
            end
            gstd_pkg::S_SHIFT_WR:
            begin
                q_we     = 1'b1;
                q_wdata  = q_rdata;
                idx_next = idx_reg + 1'b1;
                state_next = gstd_pkg::S_SHIFT_RD;
            end
            gstd_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    res_next = acc_reg;
                    res_next.queue_count = 5'(count_reg);
                    out_valid_next = 1'b1;
                    state_next = gstd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gstd_pkg::S_IDLE;
            end
        endcase
    end
endmodule
